// ===== rtl/core/sefm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stereo echo FIR mixer.
// No dependencies; every other file in rtl/core imports this package.
package sefm_pkg;

	localparam int TAP_COUNT  = 8;
	localparam int SAMPLE_W   = 16;
	localparam int SEND_W     = 21;
	localparam int COEF_W     = 8;
	localparam int GAIN_W     = 8;
	localparam int SHIFT_W    = 5;
	localparam int OUT_W      = 32;
	// Eight products of the most negative sample and the most negative tap reach +2**25.
	localparam int FIR_W      = 27;
	localparam int CELL_PROD_W = SAMPLE_W + COEF_W;
	localparam int FB_PROD_W  = FIR_W + GAIN_W;
	localparam int MIX_PROD_W = SEND_W + GAIN_W;
	localparam int SUM_W      = 36;
	localparam int SEND_SHIFT = 7;
	localparam int WB_SHIFT   = 14;
	localparam int CNT_W      = $clog2(TAP_COUNT);
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIR_TAPS,
		REG_FEEDBACK_GAIN,
		REG_ECHO_GAIN_LEFT,
		REG_ECHO_GAIN_RIGHT,
		REG_MAIN_GAIN_LEFT,
		REG_MAIN_GAIN_RIGHT,
		REG_OUTPUT_SHIFT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_PROD,
		ST_STORE
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} sample_t;

	typedef struct packed {
		logic signed [FIR_W-1:0] left;
		logic signed [FIR_W-1:0] right;
	} fir_pair_t;

endpackage

// ===== rtl/core/sefm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the frame input and the result output.
// Depends on sefm_pkg for the field widths.
interface sefm_frame_if;
	import sefm_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] echo_left;
	logic signed [SAMPLE_W-1:0] echo_right;
	logic signed [SEND_W-1:0]   send_left;
	logic signed [SEND_W-1:0]   send_right;
	logic signed [SEND_W-1:0]   mix_left;
	logic signed [SEND_W-1:0]   mix_right;

	modport source (output valid, echo_left, echo_right, send_left, send_right,
		mix_left, mix_right, input ready);
	modport sink (input valid, echo_left, echo_right, send_left, send_right,
		mix_left, mix_right, output ready);
endinterface

interface sefm_result_if;
	import sefm_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [OUT_W-1:0]    out_left;
	logic signed [OUT_W-1:0]    out_right;
	logic signed [SAMPLE_W-1:0] write_left;
	logic signed [SAMPLE_W-1:0] write_right;

	modport source (output valid, out_left, out_right, write_left, write_right,
		input ready);
	modport sink (input valid, out_left, out_right, write_left, write_right,
		output ready);
endinterface

// ===== rtl/core/sefm_cell.sv =====
`timescale 1ns / 1ps
// One FIR cell: holds one stereo history sample and adds its weighted sample
// to the partial sum handed over by its left neighbor. Depends on sefm_pkg.
module sefm_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               shift_en,
	input  sefm_pkg::sample_t                  sample_in,
	input  logic signed [sefm_pkg::COEF_W-1:0] coef,
	input  sefm_pkg::fir_pair_t                psum_in,
	output sefm_pkg::sample_t                  sample_out,
	output sefm_pkg::fir_pair_t                psum_out
);
	import sefm_pkg::*;

	sample_t                      sample_q;
	fir_pair_t                    psum_q;
	logic signed [CELL_PROD_W-1:0] prod_left;
	logic signed [CELL_PROD_W-1:0] prod_right;

	assign prod_left  = sample_q.left * coef;
	assign prod_right = sample_q.right * coef;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= sample_in;
		end
	end

	// The partial sum runs every cycle; it settles one cell per cycle once
	// the history stops moving.
	always_ff @(posedge clk) begin
		psum_q.left  <= psum_in.left + FIR_W'(prod_left);
		psum_q.right <= psum_in.right + FIR_W'(prod_right);
	end

	assign sample_out = sample_q;
	assign psum_out   = psum_q;

endmodule

// ===== rtl/core/stereo_echo_fir_mixer.sv =====
`timescale 1ns / 1ps
// Stereo echo FIR mixer: a row of eight cells holds the echo history and
// forms the FIR sums, followed by the feedback and output mix stages.
// A taken frame word passes through ST_RUN, where the partial sum moves through the
// eight cells one per cycle, then ST_PROD and ST_STORE, which waits for the output
// register to be free; a new frame is taken only in ST_IDLE.
// Reset (arst_n low) clears the history, the gains and all handshake state.
module stereo_echo_fir_mixer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	sefm_frame_if.sink                            frame,
	sefm_result_if.source                         result,
	input  logic                                  cfg_wr_en,
	input  logic [sefm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sefm_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import sefm_pkg::*;

	state_t            state_q, state_next;
	logic [CNT_W-1:0]  cnt_q;
	logic              take_frame;
	logic              load_result;
	logic              out_valid_q;

	logic [TAP_COUNT*COEF_W-1:0] taps_q;
	logic signed [GAIN_W-1:0]    fb_q, evl_q, evr_q, mvl_q, mvr_q;
	logic [SHIFT_W-1:0]          shift_q;

	logic signed [SEND_W-1:0] send_l_q, send_r_q, mix_l_q, mix_r_q;

	sample_t   chain_sample [TAP_COUNT];
	fir_pair_t chain_psum   [TAP_COUNT];
	sample_t   new_sample;
	fir_pair_t fir;

	logic signed [FB_PROD_W-1:0]  fbp_l_s1, fbp_r_s1, ep_l_s1, ep_r_s1;
	logic signed [MIX_PROD_W-1:0] mp_l_s1, mp_r_s1;

	logic signed [SUM_W-1:0] wsum_l, wsum_r, wsh_l, wsh_r;
	logic signed [SUM_W-1:0] osum_l, osum_r, osh_l, osh_r;
	logic signed [SAMPLE_W-1:0] wclamp_l, wclamp_r;
	logic signed [OUT_W-1:0]    oclamp_l, oclamp_r;

	logic signed [OUT_W-1:0]    out_l_q, out_r_q;
	logic signed [SAMPLE_W-1:0] wr_l_q, wr_r_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q  <= '0;
			fb_q    <= '0;
			evl_q   <= '0;
			evr_q   <= '0;
			mvl_q   <= '0;
			mvr_q   <= '0;
			shift_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FIR_TAPS:        taps_q  <= cfg_data;
				REG_FEEDBACK_GAIN:   fb_q    <= cfg_data[GAIN_W-1:0];
				REG_ECHO_GAIN_LEFT:  evl_q   <= cfg_data[GAIN_W-1:0];
				REG_ECHO_GAIN_RIGHT: evr_q   <= cfg_data[GAIN_W-1:0];
				REG_MAIN_GAIN_LEFT:  mvl_q   <= cfg_data[GAIN_W-1:0];
				REG_MAIN_GAIN_RIGHT: mvr_q   <= cfg_data[GAIN_W-1:0];
				REG_OUTPUT_SHIFT:    shift_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_next  = state_q;
		take_frame  = 1'b0;
		load_result = 1'b0;
		frame.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				frame.ready = 1'b1;
				if (frame.valid) begin
					take_frame = 1'b1;
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_q == CNT_W'(TAP_COUNT - 1)) begin
					state_next = ST_PROD;
				end
			end
			ST_PROD: begin
				state_next = ST_STORE;
			end
			ST_STORE: begin
				if (!out_valid_q || result.ready) begin
					load_result = 1'b1;
					state_next  = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take_frame) begin
			send_l_q <= frame.send_left;
			send_r_q <= frame.send_right;
			mix_l_q  <= frame.mix_left;
			mix_r_q  <= frame.mix_right;
		end
	end

	// History chain. Cell 0 holds the newest sample and uses tap 0; cell j
	// holds the sample j frames back, which tap TAP_COUNT-j weights.
	assign new_sample.left  = frame.echo_left;
	assign new_sample.right = frame.echo_right;

	for (genvar j = 0; j < TAP_COUNT; j++) begin : g_cell
		localparam int TapIdx = (j == 0) ? 0 : TAP_COUNT - j;
		sample_t   cell_sample_in;
		fir_pair_t cell_psum_in;

		if (j == 0) begin : g_head
			assign cell_sample_in = new_sample;
			assign cell_psum_in   = '0;
		end else begin : g_body
			assign cell_sample_in = chain_sample[j-1];
			assign cell_psum_in   = chain_psum[j-1];
		end

		sefm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (take_frame),
			.sample_in  (cell_sample_in),
			.coef       (taps_q[TapIdx*COEF_W +: COEF_W]),
			.psum_in    (cell_psum_in),
			.sample_out (chain_sample[j]),
			.psum_out   (chain_psum[j])
		);
	end

	assign fir = chain_psum[TAP_COUNT-1];

	// Products of the FIR sums and voice mixes with the gains.
	always_ff @(posedge clk) begin
		if (state_q == ST_PROD) begin
			fbp_l_s1 <= fir.left * fb_q;
			fbp_r_s1 <= fir.right * fb_q;
			ep_l_s1  <= fir.left * evl_q;
			ep_r_s1  <= fir.right * evr_q;
			mp_l_s1  <= mix_l_q * mvl_q;
			mp_r_s1  <= mix_r_q * mvr_q;
		end
	end

	// Echo write-back and output mix with saturation.
	always_comb begin
		wsum_l = (SUM_W'(send_l_q) <<< SEND_SHIFT) + SUM_W'(fbp_l_s1);
		wsum_r = (SUM_W'(send_r_q) <<< SEND_SHIFT) + SUM_W'(fbp_r_s1);
		wsh_l  = wsum_l >>> WB_SHIFT;
		wsh_r  = wsum_r >>> WB_SHIFT;
		osum_l = SUM_W'(mp_l_s1) + SUM_W'(ep_l_s1);
		osum_r = SUM_W'(mp_r_s1) + SUM_W'(ep_r_s1);
		osh_l  = osum_l >>> shift_q;
		osh_r  = osum_r >>> shift_q;

		priority if (wsh_l > 36'sd32767) wclamp_l = 16'sh7FFF;
		else if (wsh_l < -36'sd32768)    wclamp_l = 16'sh8000;
		else                             wclamp_l = wsh_l[SAMPLE_W-1:0];

		priority if (wsh_r > 36'sd32767) wclamp_r = 16'sh7FFF;
		else if (wsh_r < -36'sd32768)    wclamp_r = 16'sh8000;
		else                             wclamp_r = wsh_r[SAMPLE_W-1:0];

		priority if (osh_l > 36'sd2147483647) oclamp_l = 32'sh7FFF_FFFF;
		else if (osh_l < -36'sd2147483648)    oclamp_l = 32'sh8000_0000;
		else                                  oclamp_l = osh_l[OUT_W-1:0];

		priority if (osh_r > 36'sd2147483647) oclamp_r = 32'sh7FFF_FFFF;
		else if (osh_r < -36'sd2147483648)    oclamp_r = 32'sh8000_0000;
		else                                  oclamp_r = osh_r[OUT_W-1:0];
	end

	// Output register: holds a finished word while the next frame runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_result) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			out_l_q <= oclamp_l;
			out_r_q <= oclamp_r;
			wr_l_q  <= wclamp_l;
			wr_r_q  <= wclamp_r;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_left    = out_l_q;
	assign result.out_right   = out_r_q;
	assign result.write_left  = wr_l_q;
	assign result.write_right = wr_r_q;

endmodule

// ===== verif/echo_mix_check.sv =====
`timescale 1ns / 1ps
// Result checker for the stereo echo FIR mixer: tracks the register writes, predicts every
// result word from each accepted frame word, and compares them in order.
// Depends on sefm_pkg and the channel interfaces in sefm_if.sv.
module echo_mix_check
	import sefm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	sefm_frame_if                 frame,
	sefm_result_if                result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           frames_open,
	output int unsigned           mismatches
);

	localparam int unsigned MAX_REPORTS = 100;
	localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint OUT_MIN = -OUT_MAX - 1;
	localparam longint WB_MAX  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint WB_MIN  = -WB_MAX - 1;

	typedef struct {
		logic signed [OUT_W-1:0]    out_left;
		logic signed [OUT_W-1:0]    out_right;
		logic signed [SAMPLE_W-1:0] write_left;
		logic signed [SAMPLE_W-1:0] write_right;
	} echo_out_t;

	// Copy of the echo history and of the registers.
	logic signed [SAMPLE_W-1:0]   hist_left [TAP_COUNT];
	logic signed [SAMPLE_W-1:0]   hist_right [TAP_COUNT];
	logic [CNT_W-1:0]             next_slot;
	logic [TAP_COUNT*COEF_W-1:0]  taps_reg;
	logic signed [GAIN_W-1:0]     feedback_reg;
	logic signed [GAIN_W-1:0]     echo_gain_l;
	logic signed [GAIN_W-1:0]     echo_gain_r;
	logic signed [GAIN_W-1:0]     main_gain_l;
	logic signed [GAIN_W-1:0]     main_gain_r;
	logic [SHIFT_W-1:0]           shift_reg;

	echo_out_t   pending_mix [$];
	echo_out_t   want;
	int unsigned results_checked = 0;

	initial mismatches = 0;

	function automatic longint saturate(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Pushes the new echo pair into the history and forms the write-back and output mix.
	function automatic echo_out_t predict_frame(
		input logic signed [SAMPLE_W-1:0] el,
		input logic signed [SAMPLE_W-1:0] er,
		input logic signed [SEND_W-1:0]   sl,
		input logic signed [SEND_W-1:0]   sr,
		input logic signed [SEND_W-1:0]   ml,
		input logic signed [SEND_W-1:0]   mr
	);
		echo_out_t        r;
		longint           fir_l;
		longint           fir_r;
		longint           coef;
		logic [CNT_W-1:0] slot;
		hist_left[next_slot] = el;
		hist_right[next_slot] = er;
		fir_l = 0;
		fir_r = 0;
		// Tap 0 sees the newest sample; the slots after it run from oldest to newest.
		for (int k = 0; k < TAP_COUNT; k++) begin
			slot = next_slot + CNT_W'(k);
			coef = longint'($signed(taps_reg[k*COEF_W +: COEF_W]));
			fir_l += longint'(hist_left[slot]) * coef;
			fir_r += longint'(hist_right[slot]) * coef;
		end
		next_slot = next_slot + 1'b1;
		r.write_left = SAMPLE_W'(saturate(((longint'(sl) <<< SEND_SHIFT)
			+ fir_l * longint'(feedback_reg)) >>> WB_SHIFT, WB_MIN, WB_MAX));
		r.write_right = SAMPLE_W'(saturate(((longint'(sr) <<< SEND_SHIFT)
			+ fir_r * longint'(feedback_reg)) >>> WB_SHIFT, WB_MIN, WB_MAX));
		r.out_left = OUT_W'(saturate((longint'(ml) * longint'(main_gain_l)
			+ fir_l * longint'(echo_gain_l)) >>> shift_reg, OUT_MIN, OUT_MAX));
		r.out_right = OUT_W'(saturate((longint'(mr) * longint'(main_gain_r)
			+ fir_r * longint'(echo_gain_r)) >>> shift_reg, OUT_MIN, OUT_MAX));
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("echo_mix_check: %s (t=%0t)", msg, $time);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic signed [OUT_W-1:0] seen,
		input logic signed [OUT_W-1:0] expected_v);
		if (seen !== expected_v)
			report_mismatch($sformatf("result word %0d: %s is %0d, expected %0d",
				results_checked, name, seen, expected_v));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAP_COUNT; i++) begin
				hist_left[i] = '0;
				hist_right[i] = '0;
			end
			next_slot = '0;
			taps_reg = '0;
			feedback_reg = '0;
			echo_gain_l = '0;
			echo_gain_r = '0;
			main_gain_l = '0;
			main_gain_r = '0;
			shift_reg = '0;
			pending_mix.delete();
			frames_open <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_FIR_TAPS:        taps_reg = cfg_data;
					REG_FEEDBACK_GAIN:   feedback_reg = cfg_data[GAIN_W-1:0];
					REG_ECHO_GAIN_LEFT:  echo_gain_l = cfg_data[GAIN_W-1:0];
					REG_ECHO_GAIN_RIGHT: echo_gain_r = cfg_data[GAIN_W-1:0];
					REG_MAIN_GAIN_LEFT:  main_gain_l = cfg_data[GAIN_W-1:0];
					REG_MAIN_GAIN_RIGHT: main_gain_r = cfg_data[GAIN_W-1:0];
					REG_OUTPUT_SHIFT:    shift_reg = cfg_data[SHIFT_W-1:0];
					default: ;
				endcase
			end
			// The result side is handled first, so a word can never match its own frame
			// accepted at the same edge.
			if (result.valid && result.ready) begin
				if (pending_mix.size() == 0) begin
					report_mismatch($sformatf("result word with no frame pending: out %0d/%0d",
						result.out_left, result.out_right));
				end else begin
					want = pending_mix.pop_front();
					check_field("out_left", result.out_left, want.out_left);
					check_field("out_right", result.out_right, want.out_right);
					check_field("write_left", result.write_left, want.write_left);
					check_field("write_right", result.write_right, want.write_right);
				end
				results_checked++;
			end
			if (frame.valid && frame.ready)
				pending_mix.push_back(predict_frame(frame.echo_left, frame.echo_right,
					frame.send_left, frame.send_right, frame.mix_left, frame.mix_right));
			frames_open <= pending_mix.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the stereo echo FIR mixer testbench: clock, reset, register writes, frame stimulus
// and result back-pressure, plus the final verdict.
// Depends on sefm_pkg, sefm_if.sv, the mixer RTL and echo_mix_check.sv.
module testbench;
	import sefm_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1800;
	localparam int unsigned TAIL_ITEMS   = 150;
	localparam int unsigned DRAIN_CYCLES = 32;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	localparam logic [31:0] ECHO_MIN = 32'(1) << (SAMPLE_W - 1);
	localparam logic [31:0] ECHO_MAX = ECHO_MIN - 1;
	localparam logic [31:0] SUM_MIN  = 32'(1) << (SEND_W - 1);
	localparam logic [31:0] SUM_MAX  = SUM_MIN - 1;
	localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {GAIN_W-1{1'b0}}};
	localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {GAIN_W-1{1'b1}}};

	typedef struct {
		logic signed [SAMPLE_W-1:0] echo_left;
		logic signed [SAMPLE_W-1:0] echo_right;
		logic signed [SEND_W-1:0]   send_left;
		logic signed [SEND_W-1:0]   send_right;
		logic signed [SEND_W-1:0]   mix_left;
		logic signed [SEND_W-1:0]   mix_right;
	} frame_word_t;

	typedef struct {
		logic [TAP_COUNT*COEF_W-1:0] taps;
		logic [GAIN_W-1:0]           fb;
		logic [GAIN_W-1:0]           evl;
		logic [GAIN_W-1:0]           evr;
		logic [GAIN_W-1:0]           mvl;
		logic [GAIN_W-1:0]           mvr;
		logic [SHIFT_W-1:0]          shift;
	} mix_settings_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           frames_open;
	int unsigned           mismatch_count;
	int unsigned           cycle_count = 0;
	int unsigned           frames_sent = 0;
	int unsigned           settings_loaded = 0;
	int unsigned           random_left;
	int unsigned           burst;
	bit                    idle_on = 1'b1;

	sefm_frame_if  frame_ch ();
	sefm_result_if result_ch ();

	stereo_echo_fir_mixer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	echo_mix_check mix_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (frame_ch),
		.result      (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.frames_open (frames_open),
		.mismatches  (mismatch_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: no progress after %0d cycles", cycle_count);
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value(input int unsigned w);
		case ($urandom_range(0, 9))
			0: return 32'(1) << (w - 1);
			1: return (32'(1) << (w - 1)) - 1;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return GAIN_MIN;
			1: return GAIN_MAX;
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	function automatic frame_word_t make_frame(input logic [31:0] el, input logic [31:0] er,
		input logic [31:0] sl, input logic [31:0] sr, input logic [31:0] ml,
		input logic [31:0] mr);
		frame_word_t f;
		f.echo_left = el[SAMPLE_W-1:0];
		f.echo_right = er[SAMPLE_W-1:0];
		f.send_left = sl[SEND_W-1:0];
		f.send_right = sr[SEND_W-1:0];
		f.mix_left = ml[SEND_W-1:0];
		f.mix_right = mr[SEND_W-1:0];
		return f;
	endfunction

	function automatic mix_settings_t random_settings();
		mix_settings_t s;
		if ($urandom_range(0, 3) == 0)
			s.taps = {$urandom, $urandom};
		else
			for (int b = 0; b < TAP_COUNT; b++)
				s.taps[b*COEF_W +: COEF_W] = pick_gain();
		s.fb = pick_gain();
		s.evl = pick_gain();
		s.evr = pick_gain();
		s.mvl = pick_gain();
		s.mvr = pick_gain();
		// Mostly small shifts so the mix stays audible; zero and the full shift now and then.
		case ($urandom_range(0, 7))
			0: s.shift = '0;
			1: s.shift = '1;
			2: s.shift = SHIFT_W'($urandom);
			default: s.shift = SHIFT_W'($urandom_range(0, 12));
		endcase
		return s;
	endfunction

	// Writes all seven registers on consecutive cycles; unused upper data bits carry noise.
	task automatic load_settings(input mix_settings_t s);
		cfg_reg_t              idx;
		logic [CFG_DATA_W-1:0] word;
		idx = idx.first();
		repeat (idx.num()) begin
			word = {$urandom, $urandom};
			case (idx)
				REG_FIR_TAPS:        word = s.taps;
				REG_FEEDBACK_GAIN:   word[GAIN_W-1:0] = s.fb;
				REG_ECHO_GAIN_LEFT:  word[GAIN_W-1:0] = s.evl;
				REG_ECHO_GAIN_RIGHT: word[GAIN_W-1:0] = s.evr;
				REG_MAIN_GAIN_LEFT:  word[GAIN_W-1:0] = s.mvl;
				REG_MAIN_GAIN_RIGHT: word[GAIN_W-1:0] = s.mvr;
				REG_OUTPUT_SHIFT:    word[SHIFT_W-1:0] = s.shift;
				default: ;
			endcase
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			cfg_data <= word;
			@(posedge clk);
			idx = idx.next();
		end
		cfg_wr_en <= 1'b0;
		settings_loaded++;
	endtask

	task automatic send_frame(input frame_word_t f);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			frame_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.echo_left <= f.echo_left;
		frame_ch.echo_right <= f.echo_right;
		frame_ch.send_left <= f.send_left;
		frame_ch.send_right <= f.send_right;
		frame_ch.mix_left <= f.mix_left;
		frame_ch.mix_right <= f.mix_right;
		do @(posedge clk); while (!frame_ch.ready);
		frames_sent++;
	endtask

	// Leaves the block idle: every predicted result word has been taken.
	task automatic drain_frames();
		frame_ch.valid <= 1'b0;
		do @(posedge clk); while (frames_open != 0);
	endtask

	task automatic run_random(input int unsigned count);
		repeat (count)
			send_frame(make_frame(pick_value(SAMPLE_W), pick_value(SAMPLE_W),
				pick_value(SEND_W), pick_value(SEND_W), pick_value(SEND_W),
				pick_value(SEND_W)));
		drain_frames();
	endtask

	initial begin : result_backpressure
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		frame_ch.valid <= 1'b0;
		frame_ch.echo_left <= '0;
		frame_ch.echo_right <= '0;
		frame_ch.send_left <= '0;
		frame_ch.send_right <= '0;
		frame_ch.mix_left <= '0;
		frame_ch.mix_right <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers still hold their reset values, so only the send path reaches the outputs.
		send_frame(make_frame(ECHO_MAX, ECHO_MIN, SUM_MAX, SUM_MIN, SUM_MAX, SUM_MIN));
		send_frame(make_frame(ECHO_MIN, ECHO_MAX, SUM_MIN, SUM_MAX, SUM_MIN, SUM_MAX));
		send_frame(make_frame('1, 32'd1, '1, 32'd1, '1, 32'd1));
		drain_frames();

		// All taps at the most negative value on a full ring of minimum samples gives the
		// largest FIR sum; the write-back and the output both saturate.
		load_settings('{taps: {TAP_COUNT{GAIN_MIN}}, fb: GAIN_MIN, evl: GAIN_MIN,
			evr: GAIN_MAX, mvl: GAIN_MAX, mvr: GAIN_MIN, shift: '0});
		for (int k = 0; k < 10; k++)
			send_frame(make_frame(k < 8 ? ECHO_MIN : ECHO_MAX, k < 8 ? ECHO_MAX : ECHO_MIN,
				k[0] ? SUM_MAX : SUM_MIN, k[0] ? SUM_MIN : SUM_MAX,
				k[0] ? SUM_MIN : SUM_MAX, k[0] ? SUM_MAX : SUM_MIN));
		drain_frames();

		// Full shift leaves the mix within -16 to 15, close to mute.
		load_settings('{taps: {TAP_COUNT{GAIN_MAX}}, fb: GAIN_MAX, evl: GAIN_MAX,
			evr: GAIN_MAX, mvl: GAIN_MIN, mvr: GAIN_MAX, shift: '1});
		send_frame(make_frame(ECHO_MAX, ECHO_MAX, SUM_MAX, SUM_MAX, SUM_MIN, SUM_MAX));
		send_frame(make_frame(ECHO_MIN, ECHO_MIN, SUM_MIN, SUM_MIN, SUM_MAX, SUM_MIN));
		send_frame(make_frame(ECHO_MAX, ECHO_MIN, '0, '0, '1, '1));
		send_frame(make_frame('0, '0, '0, '0, '0, '0));
		drain_frames();

		// Distinct taps and distinct samples show the order in which the history is weighted.
		load_settings('{taps: 64'h07_06_05_04_03_02_01_80, fb: 8'h40, evl: 8'h01,
			evr: 8'h01, mvl: 8'h01, mvr: 8'hff, shift: 5'd1});
		for (int k = 0; k < 8; k++)
			send_frame(make_frame(32'((k + 1) * 1000), 32'(-(k + 1) * 700),
				32'(k * 5000), 32'(-k * 3000), 32'(k), 32'(-k)));
		drain_frames();

		random_left = RANDOM_ITEMS;
		while (random_left > 0) begin
			burst = $urandom_range(40, 180);
			if (burst > random_left)
				burst = random_left;
			idle_on = ($urandom_range(0, 3) != 0);
			load_settings(random_settings());
			run_random(burst);
			random_left -= burst;
		end

		idle_on = 1'b0;
		load_settings(random_settings());
		run_random(TAIL_ITEMS);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("testbench: %0d frames through %0d register settings, with saturating FIR,",
			frames_sent, settings_loaded);
		$display("testbench: write-back and output extremes, muting shifts and random stalls");
		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/sefm_pkg.sv
rtl/core/sefm_if.sv
rtl/core/sefm_cell.sv
rtl/core/stereo_echo_fir_mixer.sv
verif/echo_mix_check.sv
verif/testbench.sv
